FILE: src/rlee_pkg.sv
// ----------------------------------------------------------------------------
// rlee_pkg
// Shared types and constants of the escape-byte run-length encoder.
// ----------------------------------------------------------------------------
package rlee_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CONTROL_CODE = 2'd0;
    localparam logic [1:0] REG_MAX_RUN      = 2'd1;
    localparam logic [1:0] REG_SKIP_BYTES   = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values and format constants
    localparam logic [7:0] CONTROL_RESET = 8'h80;
    localparam logic [7:0] RUN_CAP       = 8'd250;
    localparam logic [7:0] RUN_FLOOR     = 8'd2;
    localparam logic [7:0] END_CODE      = 8'hFF;

    // Default depth of the token queue
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0]  control_code;
        logic [7:0]  max_run;
        logic [15:0] skip_bytes;
    } cfg_t;

    typedef enum logic [1:0] {
        TOK_NONE = 2'd0,
        TOK_LIT  = 2'd1,
        TOK_ESC  = 2'd2,
        TOK_RUN  = 2'd3
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] val;
        logic [7:0] cnt;
    } tok_t;

    // One queue entry: up to two tokens and the end-marker flag
    typedef struct packed {
        tok_t a;
        tok_t b;
        logic fin;
    } entry_t;

endpackage

FILE: src/rlee_fifo.sv
// ----------------------------------------------------------------------------
// rlee_fifo
// Small register queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module rlee_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign ready    = (count_reg != FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = store_reg[rd_ptr_reg];
    assign do_wr    = push && ready;
    assign do_rd    = pop && valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/rlee_front.sv
// ----------------------------------------------------------------------------
// rlee_front
// Accepts input beats, tracks header skip and the current run, and turns
// each run decision into token entries for the queue.
// ----------------------------------------------------------------------------
module rlee_front
    import rlee_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // is_last
    input  logic       q_ready,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [7:0]  held_reg, held_next;
    logic [7:0]  run_reg, run_next;
    logic [15:0] skipped_reg, skipped_next;
    logic [7:0]  limit;
    logic        accept;
    entry_t      ent;

    // Token for a held run
    function automatic tok_t make_tok(input logic [7:0] h, input logic [7:0] r,
                                      input logic [7:0] cc);
        tok_t t;
        t.val = h;
        t.cnt = r;
        if (r >= 8'd2) begin
            t.kind = TOK_RUN;
        end else if (r == 8'd1) begin
            t.kind = (h == cc) ? TOK_ESC : TOK_LIT;
        end else begin
            t.kind = TOK_NONE;
        end
        return t;
    endfunction

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // Run cap clamped to the documented range
    always_comb begin
        if (cfg.max_run < RUN_FLOOR) begin
            limit = RUN_FLOOR;
        end else if (cfg.max_run > RUN_CAP) begin
            limit = RUN_CAP;
        end else begin
            limit = cfg.max_run;
        end
    end

    // Classify the beat
    always_comb begin
        held_next    = held_reg;
        run_next     = run_reg;
        skipped_next = skipped_reg;
        ent.a        = '{kind: TOK_NONE, val: '0, cnt: '0};
        ent.b        = '{kind: TOK_NONE, val: '0, cnt: '0};
        ent.fin      = 1'b0;
        if (accept) begin
            priority if (skipped_reg < cfg.skip_bytes) begin
                skipped_next = skipped_reg + 1'b1;
            end else if (run_reg != '0 && s_tdata == held_reg && run_reg < limit) begin
                run_next = run_reg + 1'b1;
            end else begin
                ent.a     = make_tok(held_reg, run_reg, cfg.control_code);
                held_next = s_tdata;
                run_next  = 8'd1;
            end
            // End of block: flush and restart the header skip
            if (s_tlast) begin
                ent.b        = make_tok(held_next, run_next, cfg.control_code);
                ent.fin      = 1'b1;
                held_next    = '0;
                run_next     = '0;
                skipped_next = '0;
            end
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.a.kind != TOK_NONE || ent.fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            run_reg     <= '0;
            skipped_reg <= '0;
        end else begin
            held_reg    <= held_next;
            run_reg     <= run_next;
            skipped_reg <= skipped_next;
        end
    end

endmodule

FILE: src/rlee_back.sv
// ----------------------------------------------------------------------------
// rlee_back
// Takes token entries from the queue and plays them out one byte per beat
// through a registered output stage.
// ----------------------------------------------------------------------------
module rlee_back
    import rlee_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast      // out_last
);

    logic       work_valid_reg, work_valid_next;
    entry_t     entry_reg, entry_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic [1:0] len_a, len_b;
    logic [3:0] len_ab, total;
    logic [3:0] off_b, off_e;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       out_free, advance, done;

    // Byte count of one token
    function automatic logic [1:0] tok_len(input tok_kind_t k);
        logic [1:0] n;
        unique case (k)
            TOK_RUN:  n = 2'd3;
            TOK_ESC:  n = 2'd2;
            TOK_LIT:  n = 2'd1;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

    // Byte idx of one token
    function automatic logic [7:0] tok_byte(input tok_t t, input logic [1:0] idx,
                                            input logic [7:0] cc);
        logic [7:0] b;
        unique case (t.kind)
            TOK_RUN: begin
                b = (idx == 2'd0) ? cc : ((idx == 2'd1) ? t.cnt : t.val);
            end
            TOK_ESC: begin
                b = (idx == 2'd0) ? cc : 8'h00;
            end
            default: begin
                b = t.val;
            end
        endcase
        return b;
    endfunction

    // Locate the current step within token a, token b and the end marker
    always_comb begin
        len_a  = tok_len(entry_reg.a.kind);
        len_b  = tok_len(entry_reg.b.kind);
        len_ab = {2'b00, len_a} + {2'b00, len_b};
        total  = len_ab + (entry_reg.fin ? 4'd4 : 4'd0);
        off_b  = step_reg - {2'b00, len_a};
        off_e  = step_reg - len_ab;
        cur_last = 1'b0;
        if (step_reg < {2'b00, len_a}) begin
            cur_byte = tok_byte(entry_reg.a, step_reg[1:0], cfg.control_code);
        end else if (step_reg < len_ab) begin
            cur_byte = tok_byte(entry_reg.b, off_b[1:0], cfg.control_code);
        end else begin
            cur_byte = off_e[0] ? END_CODE : cfg.control_code;
            cur_last = (off_e[1:0] == 2'd3);
        end
    end

    // Sequencer and output stage
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        advance  = work_valid_reg && out_free;
        done     = advance && (step_reg == total - 4'd1);
        q_pop    = q_valid && (!work_valid_reg || done);

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = cur_byte;
            out_last_next  = cur_last;
        end

        work_valid_next = work_valid_reg;
        entry_next      = entry_reg;
        step_next       = step_reg;
        priority if (q_pop) begin
            work_valid_next = 1'b1;
            entry_next      = q_entry;
            step_next       = '0;
        end else if (done) begin
            work_valid_next = 1'b0;
        end else if (advance) begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg    <= entry_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Step never runs past the bytes of the entry in hand
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        work_valid_reg |-> step_reg < total)
        else $error("step beyond entry length");

    // The closing beat of a block is always the end code
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_last_reg |-> out_data_reg == END_CODE)
        else $error("last beat is not the end code");

    // A popped entry starts at its first byte
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> work_valid_reg && step_reg == 4'd0)
        else $error("popped entry not loaded");

endmodule

FILE: src/rle_escape_code_encoder.sv
// ----------------------------------------------------------------------------
// rle_escape_code_encoder
// Run-length encoder with an escape byte and a closing end marker.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_tvalid/s_tready carry one raw byte each; s_tlast marks
//   the final byte of a block. The first skip_bytes bytes of every block are
//   dropped. Runs of two or more equal bytes go out as control, count, value;
//   a lone control byte as control, 0; any other lone byte as itself. The
//   last beat of a block flushes the run and appends control, FF, control,
//   FF, with m_tlast on the final FF.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while the
//   block is idle: index 0 control code, 1 run cap, 2 header skip count.
//   Bytes caused by an input beat pass the token queue, the entry register and
//   the output register on their way to m_tdata. The sequencer emits one byte
//   per cycle while m_tready is high. A beat causes the bytes of its tokens
//   (one for a lone literal, two for a lone control code, up to ten at block
//   end); the front takes a beat per cycle while the token queue has room.
//   Reset clears the run state and the queue and loads the register
//   defaults. When m_tready is low the output beat holds, the sequencer
//   waits, and the queue fills until s_tready drops.
// ----------------------------------------------------------------------------
module rle_escape_code_encoder
    import rlee_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    input  logic                  s_tlast,    // is_last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] out_byte
    output logic                  m_tlast     // out_last
);

    cfg_t   cfg_reg, cfg_next;
    logic   q_push, q_ready, q_pop, q_valid;
    entry_t q_in, q_out;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_CONTROL_CODE: cfg_next.control_code = cfg_wdata[7:0];
                REG_MAX_RUN:      cfg_next.max_run      = cfg_wdata[7:0];
                REG_SKIP_BYTES:   cfg_next.skip_bytes   = cfg_wdata;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.control_code <= CONTROL_RESET;
            cfg_reg.max_run      <= RUN_CAP;
            cfg_reg.skip_bytes   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rlee_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    rlee_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    rlee_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sim/rle_escape_code_encoder_tb.sv
// ----------------------------------------------------------------------------
// rle_escape_code_encoder_tb
// Self-checking bench for the escape-byte run-length encoder.
// ----------------------------------------------------------------------------
// A bit-accurate software encoder runs beside the block. Every input beat it
// accepts is encoded into a queue of expected output bytes, and each output
// beat is checked against the head of that queue. Directed blocks cover
// literals, escapes, run splitting at the floor and the cap, header skipping
// and extreme control codes. Random blocks then run under four idle and
// stall mixes, with the registers reprogrammed between phases.
// ----------------------------------------------------------------------------
module rle_escape_code_encoder_tb;
    import rlee_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } out_beat_t;

    // DUT connections
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [7:0] data_byte
    logic                  s_tlast;    // is_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;    // [7:0] out_byte
    logic                  m_tlast;    // out_last

    // Encoder shadow: registers and run state
    logic [7:0]  ctrl_code;
    logic [7:0]  run_cap_cfg;
    logic [15:0] skip_cfg;
    logic [7:0]  held_val;
    logic [7:0]  run_count;
    logic [15:0] skipped;

    out_beat_t expected_stream[$];
    int        mismatch_count = 0;
    int        sent_items     = 0;
    int        idle_pct       = 0;
    int        stall_pct      = 0;

    rle_escape_code_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random back-pressure on the output side
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Encoder shadow
    // ------------------------------------------------------------------------
    function automatic int unsigned run_limit();
        if (run_cap_cfg < RUN_FLOOR)
            return RUN_FLOOR;
        if (run_cap_cfg > RUN_CAP)
            return RUN_CAP;
        return run_cap_cfg;
    endfunction

    function automatic void append_byte(input logic [7:0] b, input logic fin);
        out_beat_t beat;
        beat.data = b;
        beat.fin  = fin;
        expected_stream.push_back(beat);
    endfunction

    // Emit the token for whatever run is held, then clear it
    function automatic void flush_run();
        if (run_count >= 2) begin
            append_byte(ctrl_code, 1'b0);
            append_byte(run_count, 1'b0);
            append_byte(held_val, 1'b0);
        end else if (run_count == 1) begin
            if (held_val == ctrl_code) begin
                append_byte(ctrl_code, 1'b0);
                append_byte(8'h00, 1'b0);
            end else begin
                append_byte(held_val, 1'b0);
            end
        end
        run_count = 8'd0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        if (skipped < skip_cfg) begin
            skipped = skipped + 16'd1;
        end else if (run_count != 0 && b == held_val && run_count < run_limit()) begin
            run_count = run_count + 8'd1;
        end else begin
            flush_run();
            held_val  = b;
            run_count = 8'd1;
        end
        // End of block: flush and close with the end marker
        if (fin) begin
            flush_run();
            append_byte(ctrl_code, 1'b0);
            append_byte(END_CODE, 1'b0);
            append_byte(ctrl_code, 1'b0);
            append_byte(END_CODE, 1'b1);
            held_val = 8'd0;
            run_count = 8'd0;
            skipped = 16'd0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_output
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_stream.size() == 0) begin
                note_mismatch($sformatf("unexpected beat: data %02h last %0b",
                                        m_tdata, m_tlast));
            end else begin
                want = expected_stream.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.fin)
                    note_mismatch($sformatf("expected data %02h last %0b, got %02h last %0b",
                                            want.data, want.fin, m_tdata, m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(posedge aclk);
        while (!s_tready);
        encode_byte(b, fin);
        sent_items++;
        @(negedge aclk);
    endtask

    // Drain everything expected, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_stream.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] ctrl, input logic [7:0] cap,
                              input logic [15:0] skip);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CONTROL_CODE;
        cfg_wdata <= {8'h00, ctrl};
        @(negedge aclk);
        cfg_addr  <= REG_MAX_RUN;
        cfg_wdata <= {8'h00, cap};
        @(negedge aclk);
        cfg_addr  <= REG_SKIP_BYTES;
        cfg_wdata <= skip;
        @(negedge aclk);
        cfg_we <= 1'b0;
        ctrl_code   = ctrl;
        run_cap_cfg = cap;
        skip_cfg    = skip;
    endtask

    // One block: header bytes, then runs drawn around the control code
    task automatic send_block(input int body_len);
        logic [7:0] seq[$];
        logic [7:0] v;
        int         rep;
        int         lim;
        int         cut;
        lim = run_limit();
        repeat (skip_cfg) seq.push_back(8'($urandom_range(255)));
        while (seq.size() < skip_cfg + body_len) begin
            case ($urandom_range(3))
                0:       v = ctrl_code;
                1:       v = 8'($urandom_range(3));
                default: v = 8'($urandom_range(255));
            endcase
            if ($urandom_range(4) == 0 && lim <= 12)
                rep = $urandom_range(lim + 2);
            else
                rep = $urandom_range(1, 4);
            repeat (rep) seq.push_back(v);
        end
        // Occasionally a truncated block, possibly ending inside the header
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut)
                void'(seq.pop_back());
        end
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset defaults: literals, lone and paired control codes, a short run
    task automatic test_default_tokens();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Caps below the floor behave as two
    task automatic test_run_floor();
        set_config(8'h80, 8'd0, 16'd0);
        repeat (4) send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
        set_config(8'h80, 8'd1, 16'd0);
        repeat (2) send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_control_extremes();
        set_config(8'h00, 8'd3, 16'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_config(8'hFF, 8'd250, 16'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Header skip, including a block that ends before the header is over
    task automatic test_header_skip();
        set_config(8'h80, 8'd250, 16'd2);
        send_byte(8'h11, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
        set_config(8'h80, 8'd250, 16'hFFFF);
        send_byte(8'h44, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h44, 1'b1);
    endtask

    // Cap above 250 acts as 250: a long run splits into 250 and the rest
    task automatic test_run_cap();
        set_config(8'h80, 8'd255, 16'd0);
        repeat (252) send_byte(8'hC3, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic run_random_phase(input int idle, input int stall, input int n_items);
        int target;
        logic [7:0] cap;
        cap = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
        set_config(8'($urandom_range(255)), cap, 16'($urandom_range(3)));
        idle_pct  = idle;
        stall_pct = stall;
        target = sent_items + n_items;
        while (sent_items < target)
            send_block($urandom_range(1, 24));
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 25);
        run_random_phase(63, 0, 25);
        run_random_phase(0, 63, 25);
        run_random_phase(25, 25, 25);
    endtask

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_CONTROL_CODE;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        ctrl_code   = CONTROL_RESET;
        run_cap_cfg = RUN_CAP;
        skip_cfg    = 16'd0;
        held_val    = 8'd0;
        run_count   = 8'd0;
        skipped     = 16'd0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_tokens();
        test_run_floor();
        test_control_extremes();
        test_header_skip();
        test_run_cap();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0 && expected_stream.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
